// File: rtl/core/assert_macros.svh
// Assertion macros shared by the kerning lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");

// Condition must never be true at a clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: rtl/core/kph_pkg.sv
// Shared constants, types and codes for the kerning pair lookup block.
`timescale 1ns / 1ps
`default_nettype none

package kph_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_GLYPH_BITS  = 16;

    // Hash multipliers
    localparam int HASH_MUL_FIRST  = 367;
    localparam int HASH_MUL_SECOND = 31;

    // Fixed field widths
    localparam int SLOT_W      = 10;
    localparam int AMOUNT_W    = 16;
    localparam int SCALE_W     = 24;
    localparam int SCALED_W    = 40;
    localparam int SIZE_LOG2_W = 4;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;

    localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RESET = SIZE_LOG2_W'(10);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TABLE_SIZE_LOG2 = 1'b0,
        CFG_SCALE_FACTOR    = 1'b1
    } cfg_reg_t;

    // Input command codes
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    // Probe sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } probe_state_t;

    // Result handed from the probe unit to the output stage
    typedef struct packed {
        logic                       found;
        logic signed [AMOUNT_W-1:0] raw;
    } kph_result_t;

endpackage

`default_nettype wire

// File: rtl/core/kph_table_mem.sv
// Single-port-write, single-port-read synchronous table memory.
`timescale 1ns / 1ps
`default_nettype none

module kph_table_mem #(
    parameter int DEPTH = kph_pkg::DEF_TABLE_DEPTH,
    parameter int WIDTH = 49
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/kph_probe.sv
// Probe sequencer: clearing pass, slot writes, hashing and linear probing.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kph_probe #(
    parameter int TABLE_DEPTH = kph_pkg::DEF_TABLE_DEPTH,
    parameter int GLYPH_BITS  = kph_pkg::DEF_GLYPH_BITS,
    localparam int AW         = $clog2(TABLE_DEPTH),
    localparam int ENTRY_W    = 1 + 2 * GLYPH_BITS + kph_pkg::AMOUNT_W
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // item in
    input  wire logic                               in_valid,
    output      logic                               in_ready,
    input  wire logic                               in_command,
    input  wire logic [kph_pkg::SLOT_W-1:0]         in_slot,
    input  wire logic                               in_occupied,
    input  wire logic [GLYPH_BITS-1:0]              in_first,
    input  wire logic [GLYPH_BITS-1:0]              in_second,
    input  wire logic signed [kph_pkg::AMOUNT_W-1:0] in_amount,
    // slot mask of the table size in use
    input  wire logic [AW-1:0]                      mask,
    // table memory
    output      logic                               mem_we,
    output      logic [AW-1:0]                      mem_waddr,
    output      logic [ENTRY_W-1:0]                 mem_wdata,
    output      logic                               mem_re,
    output      logic [AW-1:0]                      mem_raddr,
    input  wire logic [ENTRY_W-1:0]                 mem_rdata,
    // result out
    output      logic                               res_valid,
    input  wire logic                               res_ready,
    output      kph_pkg::kph_result_t               res
);

    localparam int HW = GLYPH_BITS + 10;
    localparam int AMT_LSB = 1 + 2 * GLYPH_BITS;

    kph_pkg::probe_state_t state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          cnt_reg, cnt_next;
    logic [GLYPH_BITS-1:0]  first_reg, first_next;
    logic [GLYPH_BITS-1:0]  second_reg, second_next;
    kph_pkg::kph_result_t   res_reg, res_next;

    logic [HW-1:0]          hash_full;
    logic [31:0]            slot_wide;
    logic                   slot_in_range;
    logic                   ent_valid;
    logic [GLYPH_BITS-1:0]  ent_first;
    logic [GLYPH_BITS-1:0]  ent_second;
    logic signed [kph_pkg::AMOUNT_W-1:0] ent_amount;

    assign hash_full = HW'(in_first) * HW'(kph_pkg::HASH_MUL_FIRST)
                     + HW'(in_second) * HW'(kph_pkg::HASH_MUL_SECOND);
    assign slot_wide     = 32'(in_slot);
    assign slot_in_range = (slot_wide < 32'(TABLE_DEPTH));

    assign ent_valid  = mem_rdata[0];
    assign ent_first  = mem_rdata[GLYPH_BITS:1];
    assign ent_second = mem_rdata[2*GLYPH_BITS:GLYPH_BITS+1];
    assign ent_amount = mem_rdata[AMT_LSB+kph_pkg::AMOUNT_W-1:AMT_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kph_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        res_next     = res_reg;
        in_ready     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = slot_wide[AW-1:0];
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = idx_reg;
        res_valid    = 1'b0;

        unique case (state_reg)
            kph_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = kph_pkg::ST_IDLE;
                end
            end

            kph_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_command == kph_pkg::CMD_WRITE)
                    begin
                        mem_we = slot_in_range;
                        if (in_occupied)
                        begin
                            mem_wdata = {in_amount, in_second, in_first, 1'b1};
                        end
                        res_next   = '0;
                        state_next = kph_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next    = hash_full[AW-1:0] & mask;
                        cnt_next    = '0;
                        first_next  = in_first;
                        second_next = in_second;
                        state_next  = kph_pkg::ST_READ;
                    end
                end
            end

            kph_pkg::ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = kph_pkg::ST_CMP;
            end

            kph_pkg::ST_CMP:
            begin
                priority if (!ent_valid)
                begin
                    res_next   = '0;
                    state_next = kph_pkg::ST_DONE;
                end
                else if (ent_first == first_reg && ent_second == second_reg)
                begin
                    res_next.found = 1'b1;
                    res_next.raw   = ent_amount;
                    state_next     = kph_pkg::ST_DONE;
                end
                else if (cnt_reg == mask)
                begin
                    // full pass over the slots in use
                    res_next   = '0;
                    state_next = kph_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = (idx_reg + 1'b1) & mask;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = kph_pkg::ST_READ;
                end
            end

            kph_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = kph_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kph_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    `ASSERT_NEVER(a_no_rw_same_cycle, clk, rst_n, mem_we && mem_re)
    `ASSERT_ALWAYS(a_cmp_after_read, clk, rst_n,
        state_reg == kph_pkg::ST_CMP |-> $past(state_reg) == kph_pkg::ST_READ)
    `ASSERT_ALWAYS(a_idx_in_mask, clk, rst_n,
        state_reg == kph_pkg::ST_READ |-> (idx_reg & ~mask) == '0)
    `ASSERT_ALWAYS(a_cnt_bounded, clk, rst_n,
        state_reg == kph_pkg::ST_CMP |-> cnt_reg <= mask)

endmodule

`default_nettype wire

// File: rtl/core/kph_out_stage.sv
// Output stage: scales the amount and holds the result beat for the master side.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kph_out_stage (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                res_valid,
    output      logic                                res_ready,
    input  wire kph_pkg::kph_result_t                res,
    input  wire logic [kph_pkg::SCALE_W-1:0]         scale,
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic                                pair_found,
    output      logic signed [kph_pkg::AMOUNT_W-1:0] raw_amount,
    output      logic signed [kph_pkg::SCALED_W-1:0] scaled_amount
);

    localparam int PROD_W = kph_pkg::AMOUNT_W + kph_pkg::SCALE_W + 1;

    logic                                valid_reg;
    logic                                found_reg;
    logic signed [kph_pkg::AMOUNT_W-1:0] raw_reg;
    logic signed [kph_pkg::SCALED_W-1:0] scaled_reg;
    logic signed [PROD_W-1:0]            product;
    logic                                load;

    assign res_ready = !valid_reg || out_ready;
    assign load      = res_valid && res_ready;
    assign product   = PROD_W'(res.raw) * $signed({1'b0, scale});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg  <= res.found;
            raw_reg    <= res.raw;
            scaled_reg <= product[kph_pkg::SCALED_W-1:0];
        end
    end

    assign out_valid     = valid_reg;
    assign pair_found    = found_reg;
    assign raw_amount    = raw_reg;
    assign scaled_amount = scaled_reg;

    `ASSERT_ALWAYS(a_miss_is_zero, clk, rst_n,
        valid_reg && !found_reg |-> raw_reg == '0 && scaled_reg == '0)

endmodule

`default_nettype wire

// File: rtl/core/kern_pair_hash_lookup.sv
// Top level of the glyph-pair kerning lookup block.
`timescale 1ns / 1ps
`default_nettype none

// Kerning pair store with hashed lookup. The table of TABLE_DEPTH entries
// lives in one synchronous RAM. A beat with s_tuser = 0 writes one slot
// (slot_occupied = 1 loads the pair and amount, 0 empties it; slots at or
// beyond TABLE_DEPTH are ignored); s_tuser = 1 looks a pair up. The start
// slot is (first*367 + second*31) masked to 2^table_size_log2 slots, the
// size register clamped to 1..floor(log2(TABLE_DEPTH)). Probing walks
// forward with wrap-around and stops at a match, an empty slot, or after one
// full pass (miss). Each item yields exactly one result beat: pair_found,
// the raw amount and raw * scale_factor (unsigned Q8.16), all zero on a miss
// or a write. A write goes from idle straight to the result state; a lookup
// runs ST_READ then ST_CMP for each probed slot: one RAM read, then a compare.
// The result sits in an output register, so the next item is taken while an
// earlier result still waits on m_tready. After reset the block clears the
// RAM, one slot a cycle, with s_tready low; configuration writes are taken
// at any time but belong in idle periods.
module kern_pair_hash_lookup #(
    parameter int TABLE_DEPTH = kph_pkg::DEF_TABLE_DEPTH,
    parameter int GLYPH_BITS  = kph_pkg::DEF_GLYPH_BITS,
    localparam int IN_BITS    = kph_pkg::SLOT_W + 1 + 2 * GLYPH_BITS + kph_pkg::AMOUNT_W,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((kph_pkg::AMOUNT_W + kph_pkg::SCALED_W + 7) / 8) * 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [kph_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kph_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // slot_index, slot_occupied, first_glyph, second_glyph, kern_amount
    input  wire logic [IN_W-1:0]                 s_tdata,
    // command
    input  wire logic                            s_tuser,
    // result stream
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // raw_amount, scaled_amount
    output      logic [OUT_W-1:0]                m_tdata,
    // pair_found
    output      logic                            m_tuser
);

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int LOG2_MAX = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int UL_W     = $clog2(LOG2_MAX + 1);
    localparam int ENTRY_W  = 1 + 2 * GLYPH_BITS + kph_pkg::AMOUNT_W;

    localparam int OFS_OCC    = kph_pkg::SLOT_W;
    localparam int OFS_FIRST  = OFS_OCC + 1;
    localparam int OFS_SECOND = OFS_FIRST + GLYPH_BITS;
    localparam int OFS_AMOUNT = OFS_SECOND + GLYPH_BITS;

    // Configuration registers
    logic [kph_pkg::SIZE_LOG2_W-1:0] size_log2_reg;
    logic [kph_pkg::SCALE_W-1:0]     scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= kph_pkg::SIZE_LOG2_RESET;
            scale_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (kph_pkg::cfg_reg_t'(cfg_index))
                kph_pkg::CFG_TABLE_SIZE_LOG2:
                    size_log2_reg <= cfg_data[kph_pkg::SIZE_LOG2_W-1:0];
                kph_pkg::CFG_SCALE_FACTOR:
                    scale_reg <= cfg_data[kph_pkg::SCALE_W-1:0];
                default:
                    scale_reg <= scale_reg;
            endcase
        end
    end

    // Clamp the size to the RAM and build the slot mask
    logic [UL_W-1:0] used_log2;
    logic [AW-1:0]   mask;

    always_comb
    begin
        priority if (size_log2_reg == '0)
            used_log2 = UL_W'(1);
        else if (32'(size_log2_reg) > 32'(LOG2_MAX))
            used_log2 = UL_W'(LOG2_MAX);
        else
            used_log2 = UL_W'(size_log2_reg);
    end

    assign mask = ~({AW{1'b1}} << used_log2);

    // Input beat fields
    logic [kph_pkg::SLOT_W-1:0]           in_slot;
    logic                                 in_occupied;
    logic [GLYPH_BITS-1:0]                in_first;
    logic [GLYPH_BITS-1:0]                in_second;
    logic signed [kph_pkg::AMOUNT_W-1:0]  in_amount;

    assign in_slot     = s_tdata[kph_pkg::SLOT_W-1:0];
    assign in_occupied = s_tdata[OFS_OCC];
    assign in_first    = s_tdata[OFS_FIRST +: GLYPH_BITS];
    assign in_second   = s_tdata[OFS_SECOND +: GLYPH_BITS];
    assign in_amount   = s_tdata[OFS_AMOUNT +: kph_pkg::AMOUNT_W];

    // Probe unit <-> table RAM
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    logic                 res_valid;
    logic                 res_ready;
    kph_pkg::kph_result_t res;

    kph_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    kph_probe #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .GLYPH_BITS  (GLYPH_BITS)
    ) u_probe (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_command  (s_tuser),
        .in_slot     (in_slot),
        .in_occupied (in_occupied),
        .in_first    (in_first),
        .in_second   (in_second),
        .in_amount   (in_amount),
        .mask        (mask),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Scaling and output register
    logic                                pair_found;
    logic signed [kph_pkg::AMOUNT_W-1:0] raw_amount;
    logic signed [kph_pkg::SCALED_W-1:0] scaled_amount;

    kph_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .scale         (scale_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .pair_found    (pair_found),
        .raw_amount    (raw_amount),
        .scaled_amount (scaled_amount)
    );

    assign m_tuser = pair_found;
    assign m_tdata = OUT_W'({scaled_amount, raw_amount});

endmodule

`default_nettype wire
